>>> src/tqcs_pkg.sv
// ============================================================================
// tqcs_pkg
// Shared types, constants and codes for the tandem queue coupling sampler.
// ============================================================================
`default_nettype none

package tqcs_pkg;

    // Network shape
    localparam int QUEUES = 4;
    localparam int EVENTS = 3 * QUEUES;

    // Field widths
    localparam int KIND_W    = 2;
    localparam int EV_W      = 4;
    localparam int TBL_W     = 4;
    localparam int OCC_W     = 8;
    localparam int VAL_W     = 16;
    localparam int ACC_W     = VAL_W + $clog2(EVENTS);
    localparam int REG_IDX_W = 1;
    localparam int REG_W     = 8;

    // Event code reported when nothing was applied
    localparam logic [EV_W-1:0] NO_EVENT = EV_W'(EVENTS);

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DRAW    = 2'd2;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_CAPACITY = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_FLOOR    = 1'b1;

    // Reset values
    localparam logic [OCC_W-1:0] CAP_RESET   = 8'd100;
    localparam logic [OCC_W-1:0] FLOOR_RESET = 8'd0;
    localparam logic [OCC_W-1:0] UPPER_RESET = 8'd100;

    // Default queue depths
    localparam int MID_DEPTH_DEF = 2;
    localparam int RES_DEPTH_DEF = 2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TBL_W-1:0]  entry_index;
        logic [VAL_W-1:0]  weight;
        logic [VAL_W-1:0]  draw;
    } item_t;

    typedef struct packed {
        logic [EV_W-1:0] event_index;
        logic            coupled;
    } result_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_LOAD,
        OP_RESTART,
        OP_DRAW
    } op_t;

    // Classified command passed from front to back
    typedef struct packed {
        op_t              op;
        logic [TBL_W-1:0] index;
        logic [VAL_W-1:0] value;
    } cmd_t;

    typedef logic [QUEUES-1:0][OCC_W-1:0] occ_t;

endpackage

`default_nettype wire

>>> src/tandem_queue_coupling_sampler.sv
// ============================================================================
// tandem_queue_coupling_sampler
// Coupling sampler for a tandem network of bounded queues under shared draws.
// ============================================================================
// Items enter through a push/full queue port and results leave through an
// empty/pop queue port, one result per item, in order. A load item writes one
// Q0.16 weight of the 3*QUEUES event table (arrivals, departures, transits);
// a restart item sets the lower trajectory to floor_level and the upper one
// to capacity; a draw item picks the first event whose running weight sum
// reaches the draw and applies it to both trajectories with floor and
// capacity saturation. Each result carries the event applied (3*QUEUES when
// none) and whether the trajectories are equal afterwards. An input register
// and a small command queue sit ahead of a sequencer that does the work, so
// new items are taken while a draw is still searching. In the sequencer a
// load, restart or unused item goes to report; a draw searches, applies on
// a hit and reports. The search adds one table entry per cycle through a
// single 20-bit adder and compare, which sets the rate while results can be
// reported. capacity and floor_level are written via wr_en/wr_index/wr_data;
// the user must do so only while the block is idle, which it does not check.
// ============================================================================
`default_nettype none

module tandem_queue_coupling_sampler #(
    parameter int MID_DEPTH = tqcs_pkg::MID_DEPTH_DEF,
    parameter int RES_DEPTH = tqcs_pkg::RES_DEPTH_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  tqcs_pkg::item_t                      request,
    output logic                                 empty,
    input  wire logic                            pop,
    output tqcs_pkg::result_t                    result,
    input  wire logic                            wr_en,
    input  wire logic [tqcs_pkg::REG_IDX_W-1:0]  wr_index,
    input  wire logic [tqcs_pkg::REG_W-1:0]      wr_data
);

    import tqcs_pkg::*;

    // Configuration registers
    logic [OCC_W-1:0] capacity_reg;
    logic [OCC_W-1:0] floor_reg;

    // Front to back command queue
    logic    mid_push;
    cmd_t    mid_wcmd;
    logic    mid_full;
    logic    mid_pop;
    cmd_t    mid_rcmd;
    logic    mid_empty;

    // Back to result queue
    logic    res_push;
    result_t res_data;
    logic    res_full;

    // Hold configuration until written; unknown indexes change nothing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            floor_reg    <= FLOOR_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_CAPACITY:
                begin
                    capacity_reg <= wr_data;
                end
                REG_FLOOR:
                begin
                    floor_reg <= wr_data;
                end
                default:
                begin
                    capacity_reg <= capacity_reg;
                end
            endcase
        end
    end

    // Accept and classify items
    tqcs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .request  (request),
        .full     (full),
        .mid_push (mid_push),
        .mid_cmd  (mid_wcmd),
        .mid_full (mid_full)
    );

    // Decouple classification from execution
    tqcs_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .wdata (mid_wcmd),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_rcmd),
        .empty (mid_empty)
    );

    // Execute commands: table writes, restarts, search and update
    tqcs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .capacity    (capacity_reg),
        .floor_level (floor_reg),
        .mid_cmd     (mid_rcmd),
        .mid_empty   (mid_empty),
        .mid_pop     (mid_pop),
        .res_push    (res_push),
        .res_data    (res_data),
        .res_full    (res_full)
    );

    // Hold finished results until popped
    tqcs_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_data),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

`default_nettype wire

>>> src/tqcs_fifo.sv
// ============================================================================
// tqcs_fifo
// Small flop-based first-in first-out queue with push/full and pop/empty.
// ============================================================================
`default_nettype none

module tqcs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fifo count beyond depth");

endmodule

`default_nettype wire

>>> src/tqcs_front.sv
// ============================================================================
// tqcs_front
// Input stage: accept items, decode the kind and check the table index.
// ============================================================================
`default_nettype none

module tqcs_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  tqcs_pkg::item_t    request,
    output logic               full,
    output logic               mid_push,
    output tqcs_pkg::cmd_t     mid_cmd,
    input  wire logic          mid_full
);

    import tqcs_pkg::*;

    logic valid_reg, valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_dec;
    logic accept;

    assign full     = valid_reg && mid_full;
    assign accept   = push && !full;
    assign mid_push = valid_reg;
    assign mid_cmd  = cmd_reg;

    // Decode the item into a command; out-of-range loads become no-ops
    always_comb
    begin
        cmd_dec.op    = OP_NONE;
        cmd_dec.index = request.entry_index;
        cmd_dec.value = request.weight;
        case (request.kind)
            KIND_LOAD:
            begin
                cmd_dec.op = (request.entry_index < TBL_W'(EVENTS)) ? OP_LOAD : OP_NONE;
            end
            KIND_RESTART:
            begin
                cmd_dec.op = OP_RESTART;
            end
            KIND_DRAW:
            begin
                cmd_dec.op    = OP_DRAW;
                cmd_dec.value = request.draw;
            end
            default:
            begin
                cmd_dec.op = OP_NONE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !mid_full)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_dec;
        end
    end

endmodule

`default_nettype wire

>>> src/tqcs_back.sv
// ============================================================================
// tqcs_back
// Execution sequencer: weight table, cumulative search and trajectory update.
// ============================================================================
`default_nettype none

module tqcs_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [tqcs_pkg::OCC_W-1:0]    capacity,
    input  wire logic [tqcs_pkg::OCC_W-1:0]    floor_level,
    input  tqcs_pkg::cmd_t                     mid_cmd,
    input  wire logic                          mid_empty,
    output logic                               mid_pop,
    output logic                               res_push,
    output tqcs_pkg::result_t                  res_data,
    input  wire logic                          res_full
);

    import tqcs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_APPLY  = 4'b0100,
        S_REPORT = 4'b1000
    } state_t;

    // Apply one event to a trajectory with floor and capacity saturation
    function automatic occ_t apply_event(
        input occ_t             q,
        input logic [EV_W-1:0]  ev,
        input logic [OCC_W-1:0] cap,
        input logic [OCC_W-1:0] flr
    );
        occ_t nq;
        logic up;
        logic down;
        nq = q;
        for (int k = 0; k < QUEUES; k++)
        begin
            up   = (ev == EV_W'(k));
            down = (ev == EV_W'(QUEUES + k));
            if (k == QUEUES - 1)
            begin
                if (ev == EV_W'(3 * QUEUES - 1))
                begin
                    down = 1'b1;
                end
            end
            else
            begin
                if (ev == EV_W'(2 * QUEUES + k))
                begin
                    down = 1'b1;
                end
            end
            if (k > 0)
            begin
                if ((ev == EV_W'(2 * QUEUES + k - 1)) && (q[k-1] > flr))
                begin
                    up = 1'b1;
                end
            end
            if (down && (q[k] > flr))
            begin
                nq[k] = q[k] - 1'b1;
            end
            else if (up && (q[k] < cap))
            begin
                nq[k] = q[k] + 1'b1;
            end
        end
        return nq;
    endfunction

    state_t           state_reg, state_next;
    logic [VAL_W-1:0] weight_reg [EVENTS];
    occ_t             lower_reg, lower_next;
    occ_t             upper_reg, upper_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [VAL_W-1:0] draw_reg, draw_next;
    logic [TBL_W-1:0] idx_reg, idx_next;
    logic [EV_W-1:0]  ev_reg, ev_next;
    logic [ACC_W-1:0] acc_sum;
    logic             hit;
    logic             last;
    logic             weight_we;

    assign acc_sum = acc_reg + ACC_W'(weight_reg[idx_reg]);
    assign hit     = (acc_sum >= ACC_W'(draw_reg));
    assign last    = (idx_reg == TBL_W'(EVENTS - 1));

    assign res_data.event_index = ev_reg;
    assign res_data.coupled     = (lower_reg == upper_reg);

    always_comb
    begin
        state_next = state_reg;
        lower_next = lower_reg;
        upper_next = upper_reg;
        acc_next   = acc_reg;
        draw_next  = draw_reg;
        idx_next   = idx_reg;
        ev_next    = ev_reg;
        mid_pop    = 1'b0;
        res_push   = 1'b0;
        weight_we  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!mid_empty)
                begin
                    mid_pop    = 1'b1;
                    ev_next    = NO_EVENT;
                    state_next = S_REPORT;
                    case (mid_cmd.op)
                        OP_LOAD:
                        begin
                            weight_we = 1'b1;
                        end
                        OP_RESTART:
                        begin
                            lower_next = {QUEUES{floor_level}};
                            upper_next = {QUEUES{capacity}};
                        end
                        OP_DRAW:
                        begin
                            draw_next  = mid_cmd.value;
                            acc_next   = '0;
                            idx_next   = '0;
                            state_next = S_SEARCH;
                        end
                        default:
                        begin
                            ev_next = NO_EVENT;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                // Walk one cumulative weight per cycle
                acc_next = acc_sum;
                if (hit)
                begin
                    ev_next    = EV_W'(idx_reg);
                    state_next = S_APPLY;
                end
                else if (last)
                begin
                    ev_next    = NO_EVENT;
                    state_next = S_REPORT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_APPLY:
            begin
                lower_next = apply_event(lower_reg, ev_reg, capacity, floor_level);
                upper_next = apply_event(upper_reg, ev_reg, capacity, floor_level);
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            lower_reg <= {QUEUES{FLOOR_RESET}};
            upper_reg <= {QUEUES{UPPER_RESET}};
            for (int i = 0; i < EVENTS; i++)
            begin
                weight_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            lower_reg <= lower_next;
            upper_reg <= upper_next;
            if (weight_we)
            begin
                weight_reg[mid_cmd.index] <= mid_cmd.value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        draw_reg <= draw_next;
        idx_reg  <= idx_next;
        ev_reg   <= ev_next;
    end

    a_search_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (idx_reg < TBL_W'(EVENTS)))
        else $error("search index past table");

    a_apply_real: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |-> (ev_reg < NO_EVENT))
        else $error("apply without a selected event");

    a_report_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> (state_reg == S_IDLE) && $stable(lower_reg) && $stable(upper_reg))
        else $error("trajectories moved after report");

endmodule

`default_nettype wire

>>> bench/tandem_queue_coupling_sampler_tb.sv
// ----------------------------------------------------------------------------
// tandem_queue_coupling_sampler_tb
// Self-checking bench for the tandem queue coupling sampler: a short directed
// pass over the special cases, then register settings from the extremes
// inward, each with a reloaded weight set and random draws. Every result is
// checked against a cycle-free model of both occupancy trajectories.
// ----------------------------------------------------------------------------
module tandem_queue_coupling_sampler_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tqcs_pkg::*;

    // Kind code the block treats as a no-op
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 120;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int HOLD_ROUNDS   = 2;
    localparam int CYCLE_LIMIT   = 1000000;

    logic    clk      = 1'b0;
    logic    rst_n    = 1'b0;
    logic    push     = 1'b0;
    logic    full;
    item_t   request  = '0;
    logic    empty;
    logic    pop      = 1'b0;
    result_t result;
    logic                 wr_en    = 1'b0;
    logic [REG_IDX_W-1:0] wr_index = '0;
    logic [REG_W-1:0]     wr_data  = '0;

    tandem_queue_coupling_sampler dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .request  (request),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Model state: weight list, both trajectories and the two bounds.
    // Touched by the driver at each accepted item and by register writes,
    // which only happen while the block is idle.
    // ------------------------------------------------------------------------
    logic [VAL_W-1:0] weights [EVENTS];
    occ_t             low_occ;
    occ_t             up_occ;
    logic [OCC_W-1:0] cap_cfg;
    logic [OCC_W-1:0] flr_cfg;

    item_t   item_backlog[$];       // items waiting for the driver
    result_t pending_outcomes[$];   // predicted results, oldest first

    bit steady = 1'b0;              // when set, neither side draws random idle gaps
    int send_gap = 0;
    int rcv_gap = 0;
    int hold_count = 0;
    int holds_done = 0;
    int results_seen = 0;
    int items_sent = 0;
    int cycle_count = 0;
    int failures = 0;
    int n_arrival = 0;
    int n_depart = 0;
    int n_transit = 0;
    int n_none = 0;
    int n_coupled = 0;

    // Apply one event to one trajectory, saturating at floor and capacity.
    // A transit whose source sits at the floor moves nothing; one whose
    // destination is full still drains the source. The last queue's transit
    // leaves the network like a departure.
    function automatic occ_t shift_occupancy(occ_t occ, int ev);
        int src;
        src = ev % QUEUES;
        if (ev < QUEUES) begin
            if (occ[src] < cap_cfg)
                occ[src] = occ[src] + 1'b1;
        end
        else if (ev < EVENTS) begin
            if (occ[src] > flr_cfg) begin
                occ[src] = occ[src] - 1'b1;
                if (ev >= 2 * QUEUES && src < QUEUES - 1 && occ[src + 1] < cap_cfg)
                    occ[src + 1] = occ[src + 1] + 1'b1;
            end
        end
        return occ;
    endfunction

    // Advance the model by one item and return the result it should produce.
    function automatic result_t advance_sampler(item_t it);
        result_t          res;
        logic [ACC_W-1:0] running;
        int               pick;
        res.event_index = NO_EVENT;
        case (it.kind)
            KIND_LOAD:
                if (it.entry_index < EVENTS)
                    weights[it.entry_index] = it.weight;
            KIND_RESTART:
                for (int q = 0; q < QUEUES; q++) begin
                    low_occ[q] = flr_cfg;
                    up_occ[q]  = cap_cfg;
                end
            KIND_DRAW: begin
                // Inverse transform: first entry whose running sum reaches the draw
                pick    = EVENTS;
                running = '0;
                for (int e = 0; e < EVENTS; e++) begin
                    if (pick == EVENTS) begin
                        running = running + weights[e];
                        if (running >= it.draw)
                            pick = e;
                    end
                end
                res.event_index = EV_W'(pick);
                low_occ = shift_occupancy(low_occ, pick);
                up_occ  = shift_occupancy(up_occ, pick);
            end
            default: ;
        endcase
        res.coupled = (low_occ == up_occ);
        return res;
    endfunction

    // Idle length: mostly none or short, now and then a long one
    function automatic int idle_gap();
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic item_t make_item(logic [KIND_W-1:0] kind, int idx, int w, int d);
        item_t it;
        it.kind        = kind;
        it.entry_index = TBL_W'(idx);
        it.weight      = VAL_W'(w);
        it.draw        = VAL_W'(d);
        return it;
    endfunction

    // Mostly draws with random content; the rest reloads, restarts and noise.
    // Unused fields of each kind carry random bits too.
    function automatic item_t random_item();
        item_t it;
        int    roll;
        it.kind        = KIND_DRAW;
        it.entry_index = TBL_W'($urandom_range(0, 15));
        it.weight      = VAL_W'($urandom);
        it.draw        = VAL_W'($urandom);
        roll = $urandom_range(0, 99);
        if (roll >= 72 && roll < 76) begin
            it.draw = $urandom_range(0, 1) ? '1 : '0;
        end
        else if (roll >= 76 && roll < 88) begin
            it.kind = KIND_LOAD;
            // keep most reloads small so the total stays near one
            if (roll < 84)
                it.weight = VAL_W'($urandom_range(0, 10922));
        end
        else if (roll >= 88 && roll < 94) begin
            it.kind = KIND_RESTART;
        end
        else if (roll >= 94) begin
            it.kind = KIND_UNUSED;
        end
        return it;
    endfunction

    // {capacity, floor_level} for each random phase: extremes first,
    // floor above capacity in the middle, reset values last
    function automatic logic [2*REG_W-1:0] phase_setting(int phase);
        case (phase)
            0:       return {8'd3,   8'd0};
            1:       return {8'd255, 8'd0};
            2:       return {8'd0,   8'd0};
            3:       return {8'd255, 8'd255};
            4:       return {8'd5,   8'd5};
            5:       return {8'd6,   8'd9};
            6:       return {8'd0,   8'd255};
            7:       return {8'd12,  8'd1};
            default: return {CAP_RESET, FLOOR_RESET};
        endcase
    endfunction

    // Write one register and mirror it in the model
    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(posedge clk);
        wr_en    <= 1'b0;
        if (idx == REG_CAPACITY)
            cap_cfg = value;
        else
            flr_cfg = value;
    endtask

    // Hold until nothing is queued, offered or expected, then let the
    // sequencer drain its longest search before touching the registers
    task automatic wait_idle();
        while (item_backlog.size() != 0 || push || pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: offer the oldest backlog item, predict it on acceptance, and
    // insert random gaps between items.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            push     <= 1'b0;
            request  <= '0;
            send_gap <= 0;
        end
        else begin
            if (push && !full) begin
                pending_outcomes.push_back(advance_sampler(request));
                items_sent++;
            end
            // Free slot: either nothing offered or the offer was just taken
            if (!push || !full) begin
                if (send_gap != 0) begin
                    push     <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (item_backlog.size() != 0) begin
                    push     <= 1'b1;
                    request  <= item_backlog.pop_front();
                    send_gap <= idle_gap();
                end
                else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver hold-off: twice during the run, while plenty is still queued,
    // stop popping for a long stretch so the block fills and asserts full.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hold_count <= 0;
            holds_done <= 0;
        end
        else if (hold_count != 0) begin
            hold_count <= hold_count - 1;
        end
        else if (holds_done < HOLD_ROUNDS && results_seen >= 300 * (holds_done + 1)
                 && item_backlog.size() >= 20) begin
            hold_count <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each popped result against the oldest prediction, then
    // decide whether to pop next cycle.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin : result_monitor
        result_t want;
        if (!rst_n) begin
            pop     <= 1'b0;
            rcv_gap <= 0;
        end
        else begin
            if (pop && !empty) begin
                results_seen <= results_seen + 1;
                if (pending_outcomes.size() == 0) begin
                    $display("%0t: unexpected result: event_index %0d coupled %0b",
                             $time, result.event_index, result.coupled);
                    failures++;
                end
                else begin
                    want = pending_outcomes.pop_front();
                    if (result.event_index !== want.event_index) begin
                        $display("%0t: event_index mismatch: expected %0d actual %0d",
                                 $time, want.event_index, result.event_index);
                        failures++;
                    end
                    if (result.coupled !== want.coupled) begin
                        $display("%0t: coupled mismatch: expected %0b actual %0b",
                                 $time, want.coupled, result.coupled);
                        failures++;
                    end
                    if (want.event_index < QUEUES)
                        n_arrival++;
                    else if (want.event_index < 2 * QUEUES)
                        n_depart++;
                    else if (want.event_index < EVENTS)
                        n_transit++;
                    else
                        n_none++;
                    if (want.coupled)
                        n_coupled++;
                end
            end
            if (hold_count != 0) begin
                pop <= 1'b0;
            end
            else if (!pop || !empty) begin
                if (rcv_gap != 0) begin
                    pop     <= 1'b0;
                    rcv_gap <= rcv_gap - 1;
                end
                else begin
                    pop     <= 1'b1;
                    rcv_gap <= idle_gap();
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results still expected",
                     $time, cycle_count, pending_outcomes.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus plan
    // ------------------------------------------------------------------------
    initial begin : stimulus_plan
        item_t            it;
        int               effective;
        logic [REG_W-1:0] cap_pick;
        logic [REG_W-1:0] floor_pick;

        // Model starts from the reset state
        cap_cfg = CAP_RESET;
        flr_cfg = FLOOR_RESET;
        low_occ = '0;
        up_occ  = {QUEUES{UPPER_RESET}};
        foreach (weights[e])
            weights[e] = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, reset register values.
        // Empty weight list: a zero draw still hits the first arrival,
        // any other draw misses every entry.
        item_backlog.push_back(make_item(KIND_DRAW, 0, 0, 0));
        item_backlog.push_back(make_item(KIND_DRAW, 0, 0, 1));
        // Unused kind with every field at its top value
        item_backlog.push_back(make_item(KIND_UNUSED, 15, 16'hFFFF, 16'hFFFF));
        // Loads past the end of the list are dropped
        item_backlog.push_back(make_item(KIND_LOAD, 15, 16'hFFFF, 0));
        item_backlog.push_back(make_item(KIND_LOAD, EVENTS, 16'hFFFF, 0));
        for (int e = 0; e < EVENTS; e++)
            item_backlog.push_back(make_item(KIND_LOAD, e, 5000, 0));
        // Transit out of queue 0, last-queue transit, departure, then a miss
        item_backlog.push_back(make_item(KIND_DRAW, 0, 0, 45000));
        item_backlog.push_back(make_item(KIND_DRAW, 0, 0, 60000));
        item_backlog.push_back(make_item(KIND_DRAW, 0, 0, 25000));
        item_backlog.push_back(make_item(KIND_DRAW, 0, 0, 60001));
        item_backlog.push_back(make_item(KIND_RESTART, 0, 0, 0));
        // Full-scale weight against a full-scale draw
        item_backlog.push_back(make_item(KIND_LOAD, 0, 16'hFFFF, 0));
        item_backlog.push_back(make_item(KIND_DRAW, 0, 0, 16'hFFFF));

        // Random part: per phase, new bounds, a restart, a fresh weight set
        // summing near one, then mostly draws
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            {cap_pick, floor_pick} = phase_setting(phase);
            write_reg(REG_CAPACITY, cap_pick);
            write_reg(REG_FLOOR, floor_pick);
            steady = (phase == 2 || phase == 6);
            item_backlog.push_back(make_item(KIND_RESTART, $urandom_range(0, 15),
                                             $urandom, $urandom));
            for (int e = 0; e < EVENTS; e++)
                item_backlog.push_back(make_item(KIND_LOAD, e, $urandom_range(0, 10922),
                                                 $urandom));
            effective = 0;
            while (effective < PHASE_ITEMS) begin
                it = random_item();
                item_backlog.push_back(it);
                // ignored items do not count toward the phase size
                if (it.kind != KIND_UNUSED && !(it.kind == KIND_LOAD && it.entry_index >= EVENTS))
                    effective++;
            end
        end

        wait_idle();
        $display("Covered %0d items over %0d register settings with %0d receiver hold-offs",
                 items_sent, PHASES + 1, holds_done);
        $display("Events: %0d arrivals, %0d departures, %0d transits, %0d none; %0d coupled",
                 n_arrival, n_depart, n_transit, n_none, n_coupled);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> filelist.f
src/tqcs_pkg.sv
src/tqcs_fifo.sv
src/tqcs_front.sv
src/tqcs_back.sv
src/tandem_queue_coupling_sampler.sv
bench/tandem_queue_coupling_sampler_tb.sv
